/* design/mmn_pkg.sv */
// Shared widths and constants of the min/max normaliser.
package mmn_pkg;

    localparam int PIX_W      = 16;                 // sample and register width
    localparam int PROD_W     = 2 * PIX_W;          // magnitude of the scale numerator
    localparam int BITS_STEP  = 2;                  // quotient bits retired per cycle
    localparam int DIV_CYCLES = PROD_W / BITS_STEP; // cycles for one division
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // register index, taken from byte address bit 2
    localparam logic REG_TARGET_LOW  = 1'b0;
    localparam logic REG_TARGET_HIGH = 1'b1;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [PROD_W-1:0] prod_t;

    // input word kind: measure pass or scale pass
    typedef enum logic {MODE_MEASURE = 1'b0, MODE_SCALE = 1'b1} mode_t;

endpackage

/* design/mmn_divider.sv */
// Iterative unsigned divider, two restoring steps per cycle.
module mmn_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mmn_pkg::prod_t      dividend,
    input  mmn_pkg::pix_t       divisor,
    output logic                done,
    output mmn_pkg::prod_t      quotient
);

    logic [mmn_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    mmn_pkg::prod_t                qd_reg, qd_next;
    mmn_pkg::pix_t                 rem_reg, rem_next;
    mmn_pkg::pix_t                 den_reg, den_next;

    // two dependent restoring steps on the partial remainder
    always_comb
    begin
        logic [mmn_pkg::PIX_W:0] trial;
        mmn_pkg::pix_t           rem_w;
        mmn_pkg::prod_t          qd_w;
        trial     = '0;
        rem_w     = rem_reg;
        qd_w      = qd_reg;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_w    = '0;
            qd_w     = dividend;
            den_next = divisor;
            cnt_next = mmn_pkg::DIV_CNT_W'(mmn_pkg::DIV_CYCLES);
        end
        else if (cnt_reg != '0)
        begin
            for (int s = 0; s < mmn_pkg::BITS_STEP; s++)
            begin
                trial = {rem_w, qd_w[mmn_pkg::PROD_W-1]};
                if (trial >= {1'b0, den_reg})
                begin
                    trial = trial - {1'b0, den_reg};
                    qd_w  = {qd_w[mmn_pkg::PROD_W-2:0], 1'b1};
                end
                else
                begin
                    qd_w  = {qd_w[mmn_pkg::PROD_W-2:0], 1'b0};
                end
                rem_w = trial[mmn_pkg::PIX_W-1:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == mmn_pkg::DIV_CNT_W'(1));
        end
        rem_next = rem_w;
        qd_next  = qd_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

/* design/min_max_normalizer_core.sv */
// Top level of the min/max contrast stretch: registers, sequencer and result stage.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+---------------------------
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata
//  input    | start & !busy           | mode, first, pixel
//  result   | done (one-cycle strobe) | scaled
//
// A measure word (mode 0) updates the frame minimum and maximum at the edge
// that accepts it; busy never rises and the next word may follow at once.
// A scale word on a flat frame gives target_low in the cycle after it is
// accepted, also with no busy time. Any other scale word passes through a
// multiply state, the two-bit-per-cycle divider and a registered step that
// signs, offsets and saturates before its strobe rises. busy falls as the
// strobe rises, so such a word holds the input until then.
// Reset (rst_n low, asynchronous) clears the frame range to 0, the output
// range to 0..65535 and the sequencer. The receiver cannot stall results.
module min_max_normalizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic        first,
    input  logic [15:0] pixel,
    // result words
    output logic        done,
    output logic [15:0] scaled
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]          state_reg, state_next;
    mmn_pkg::pix_t       low_reg, low_next;
    mmn_pkg::pix_t       high_reg, high_next;
    mmn_pkg::pix_t       fmin_reg, fmin_next;
    mmn_pkg::pix_t       fmax_reg, fmax_next;
    mmn_pkg::pix_t       amag_reg, amag_next;
    logic                aneg_reg, aneg_next;
    mmn_pkg::pix_t       span_reg, span_next;
    logic                neg_reg, neg_next;
    logic                done_reg, done_next;
    mmn_pkg::pix_t       scaled_reg, scaled_next;

    logic                accept;
    logic                cfg_wr;
    logic                flat;
    logic [16:0]         diff_a;
    logic [16:0]         diff_b;
    mmn_pkg::pix_t       bmag;
    logic                bneg;
    mmn_pkg::prod_t      product;
    logic                div_start;
    logic                div_done;
    mmn_pkg::prod_t      quotient;
    logic signed [33:0]  signed_q;
    logic signed [33:0]  sum;
    mmn_pkg::pix_t       sat;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // read back the output range
    always_comb
    begin
        unique case (paddr[2])
            mmn_pkg::REG_TARGET_LOW:  prdata = {16'b0, low_reg};
            mmn_pkg::REG_TARGET_HIGH: prdata = {16'b0, high_reg};
            default:                  prdata = '0;
        endcase
    end

    // flat frame: the block returns target_low without dividing
    assign flat   = (fmax_reg <= fmin_reg);

    // signed pixel offset from the minimum and signed output span, kept as
    // sign and magnitude so the divider only sees unsigned words
    assign diff_a = {1'b0, pixel} - {1'b0, fmin_reg};
    assign diff_b = {1'b0, high_reg} - {1'b0, low_reg};
    assign bneg   = diff_b[16];
    assign bmag   = bneg ? mmn_pkg::pix_t'(-diff_b) : diff_b[15:0];

    assign product   = amag_reg * bmag;
    assign div_start = (state_reg == ST_MUL);

    mmn_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // quotient truncates toward zero: divide magnitudes, then restore sign
    assign signed_q = neg_reg ? -$signed({2'b0, quotient}) : $signed({2'b0, quotient});
    assign sum      = signed_q + $signed({18'b0, low_reg});

    // clamp to 0..65535
    always_comb
    begin
        if (sum[33])
            sat = '0;
        else if (sum[32:16] != '0)
            sat = '1;
        else
            sat = sum[15:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        fmin_next   = fmin_reg;
        fmax_next   = fmax_reg;
        amag_next   = amag_reg;
        aneg_next   = aneg_reg;
        span_next   = span_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        scaled_next = scaled_reg;

        if (cfg_wr)
        begin
            unique case (paddr[2])
                mmn_pkg::REG_TARGET_LOW:  low_next  = pwdata[15:0];
                mmn_pkg::REG_TARGET_HIGH: high_next = pwdata[15:0];
                default:                  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == mmn_pkg::MODE_MEASURE)
                    begin
                        // restart or widen the running range
                        if (first)
                        begin
                            fmin_next = pixel;
                            fmax_next = pixel;
                        end
                        else
                        begin
                            if (pixel < fmin_reg)
                                fmin_next = pixel;
                            if (pixel > fmax_reg)
                                fmax_next = pixel;
                        end
                    end
                    else if (flat)
                    begin
                        done_next   = 1'b1;
                        scaled_next = low_reg;
                    end
                    else
                    begin
                        aneg_next  = diff_a[16];
                        amag_next  = diff_a[16] ? mmn_pkg::pix_t'(-diff_a) : diff_a[15:0];
                        span_next  = fmax_reg - fmin_reg;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                // product is loaded into the divider at this edge
                neg_next   = aneg_reg ^ bneg;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next   = 1'b1;
                    scaled_next = sat;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            low_reg   <= '0;
            high_reg  <= '1;
            fmin_reg  <= '0;
            fmax_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            fmin_reg  <= fmin_next;
            fmax_reg  <= fmax_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amag_reg   <= amag_next;
        aneg_reg   <= aneg_next;
        span_reg   <= span_next;
        neg_reg    <= neg_next;
        scaled_reg <= scaled_next;
    end

    assign done   = done_reg;
    assign scaled = scaled_reg;

`ifndef NO_ASSERTIONS
    // the running range never inverts
    a_range_ordered : assert property (@(posedge clk) disable iff (!rst_n)
        fmax_reg >= fmin_reg)
        else $error("frame maximum below frame minimum");

    // a divider result only arrives while the sequencer waits for it
    a_div_in_state : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // a strobed result always leaves the block idle
    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // a scale word on a non-flat frame starts the multiply
    a_scale_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == mmn_pkg::MODE_SCALE) && !flat) |=> (state_reg == ST_MUL))
        else $error("scale word did not start the sequencer");
`endif

endmodule

/* verif/min_max_normalizer_core_tb.sv */
// Self-checking testbench of the min/max contrast stretch core.
module min_max_normalizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Hold-off after the last result before a register write: a margin on the
    // time a slow scale word takes from accept to strobe.
    localparam int SETTLE_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 104;
    localparam int MAX_REPORTS     = 40;

    typedef enum logic {ROW_WORD = 1'b0, ROW_CFG = 1'b1} row_kind_t;

    // One row of the directed table. A configuration row carries target_low
    // in pixel and target_high in want. A word row with pinned set is checked
    // against want, otherwise against the predictor.
    typedef struct packed {
        row_kind_t      kind;
        mmn_pkg::mode_t op;
        logic           first;
        mmn_pkg::pix_t  pixel;
        logic           pinned;
        mmn_pkg::pix_t  want;
    } plan_row_t;

    localparam int DIRECTED_ROWS = 29;
    localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
        // straight after reset the frame is flat at 0: result is target_low
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd1234,  1'b1, 16'd0},
        // measure with no first word: range grows from the reset 0..0
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b0, 16'd65535, 1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd0,     1'b1, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd65535, 1'b1, 16'd65535},
        // first is ignored on a scale word
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b1, 16'd32768, 1'b1, 16'd32768},
        // restart the range, then widen it both ways
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b1, 16'd1000,  1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b0, 16'd3000,  1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b0, 16'd500,   1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd500,   1'b1, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd3000,  1'b1, 16'd65535},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd1750,  1'b0, 16'd0},
        // pixels outside the measured range saturate at either end
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd0,     1'b1, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd65535, 1'b1, 16'd65535},
        // flat frame away from zero
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b1, 16'd40000, 1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd65535, 1'b1, 16'd0},
        // low above high: negative output span
        '{ROW_CFG,  mmn_pkg::MODE_MEASURE, 1'b0, 16'd60000, 1'b0, 16'd1000},
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b1, 16'd100,   1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b0, 16'd200,   1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd150,   1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd100,   1'b1, 16'd60000},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd200,   1'b1, 16'd1000},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd65535, 1'b1, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd0,     1'b1, 16'd65535},
        // zero-width output range at the bottom
        '{ROW_CFG,  mmn_pkg::MODE_MEASURE, 1'b0, 16'd0,     1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd150,   1'b1, 16'd0},
        // zero-width output range at the top
        '{ROW_CFG,  mmn_pkg::MODE_MEASURE, 1'b0, 16'd65535, 1'b0, 16'd65535},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd0,     1'b1, 16'd65535},
        '{ROW_WORD, mmn_pkg::MODE_MEASURE, 1'b1, 16'd7,     1'b0, 16'd0},
        '{ROW_WORD, mmn_pkg::MODE_SCALE,   1'b0, 16'd9,     1'b1, 16'd65535}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        mode;
    logic        first;
    logic [15:0] pixel;
    logic        done;
    logic [15:0] scaled;

    // Predictor state: frame range and output range, plus results in flight.
    mmn_pkg::pix_t cur_min;
    mmn_pkg::pix_t cur_max;
    mmn_pkg::pix_t out_low;
    mmn_pkg::pix_t out_high;
    mmn_pkg::pix_t scaled_due [$];

    // Pinned expectation of the word now on the input port (directed rows).
    logic          pin_valid;
    mmn_pkg::pix_t pin_value;

    bit gapless;
    int errors;
    int results_seen;
    int measure_words;
    int scale_words;
    int cfg_writes;
    int range_settings;
    int stall_cycles;

    min_max_normalizer_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Expected stretch of one pixel against the current frame and output range.
    // Signed arithmetic throughout; SystemVerilog division truncates toward
    // zero, which is what the block must do too.
    function automatic mmn_pkg::pix_t stretched(input mmn_pkg::pix_t p);
        longint span;
        longint num;
        longint q;
        if (cur_max <= cur_min)
            return out_low;
        span = longint'(cur_max) - longint'(cur_min);
        num  = (longint'(p) - longint'(cur_min)) * (longint'(out_high) - longint'(out_low));
        q    = num / span + longint'(out_low);
        if (q < 0)
            q = 0;
        else if (q > 65535)
            q = 65535;
        return mmn_pkg::pix_t'(q);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Sample every handshake at the rising edge. Inputs only move on the
    // falling edge and the block updates its outputs after the edge, so the
    // values read here are the ones the block saw.
    always @(posedge clk)
    begin : watch_ports
        bit            progress;
        mmn_pkg::pix_t want;
        progress = 1'b0;
        if (!rst_n)
        begin
            cur_min  = '0;
            cur_max  = '0;
            out_low  = '0;
            out_high = '1;
            scaled_due.delete();
        end
        else
        begin
            // check a result against the oldest word still waiting
            if (done)
            begin
                progress = 1'b1;
                results_seen++;
                if (scaled_due.size() == 0)
                    report_mismatch("scaled word with nothing outstanding", scaled, 0);
                else
                begin
                    want = scaled_due.pop_front();
                    if (scaled !== want)
                        report_mismatch("scaled", scaled, want);
                end
            end
            // advance the predictor on every accepted input word
            if (start && !busy)
            begin
                progress = 1'b1;
                if (mode == mmn_pkg::MODE_SCALE)
                begin
                    scale_words++;
                    scaled_due.push_back(pin_valid ? pin_value : stretched(pixel));
                end
                else
                begin
                    measure_words++;
                    if (first)
                    begin
                        cur_min = pixel;
                        cur_max = pixel;
                    end
                    else
                    begin
                        if (pixel < cur_min)
                            cur_min = pixel;
                        if (pixel > cur_max)
                            cur_max = pixel;
                    end
                end
            end
            // track the output range as the configuration port writes it
            if (psel && penable && pready)
            begin
                progress = 1'b1;
                if (pwrite)
                begin
                    cfg_writes++;
                    if (paddr == {mmn_pkg::REG_TARGET_LOW, 2'b00})
                        out_low = pwdata[15:0];
                    else if (paddr == {mmn_pkg::REG_TARGET_HIGH, 2'b00})
                        out_high = pwdata[15:0];
                end
            end
        end
        stall_cycles = progress ? 0 : stall_cycles + 1;
    end

    // Give up when no handshake of any kind has happened for too long.
    initial
    begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("** min_max_normalizer_core: FAILED **");
        $finish;
    end

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        if (gapless)
            return 0;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(20, 4);
        return $urandom_range(80, 30);
    endfunction

    // Drop start and scramble the payload, which the block must ignore.
    task automatic idle_for(input int n);
        if (n == 0)
            return;
        @(negedge clk);
        start     = 1'b0;
        mode      = 1'($urandom);
        first     = 1'($urandom);
        pixel     = 16'($urandom);
        pin_valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Present one word and hold it until the block takes it.
    task automatic send_word(input mmn_pkg::mode_t op, input logic f, input mmn_pkg::pix_t p,
                             input logic pinned, input mmn_pkg::pix_t want);
        @(negedge clk);
        start     = 1'b1;
        mode      = op;
        first     = f;
        pixel     = p;
        pin_valid = pinned;
        pin_value = want;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic send_and_gap(input mmn_pkg::mode_t op, input logic f,
                                input mmn_pkg::pix_t p);
        send_word(op, f, p, 1'b0, '0);
        idle_for(gap_len());
    endtask

    // Hold the sender until every scale word has come back, then let the
    // block settle so that a register write cannot land on work in progress.
    task automatic drain_results();
        idle_for(1);
        while (scaled_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register, then read it back.
    task automatic set_register(input logic idx, input mmn_pkg::pix_t value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'h0, value};
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        if (prdata !== {16'h0, value})
            report_mismatch("register readback", prdata, {16'h0, value});
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_output_range(input mmn_pkg::pix_t lo, input mmn_pkg::pix_t hi);
        drain_results();
        set_register(mmn_pkg::REG_TARGET_LOW, lo);
        set_register(mmn_pkg::REG_TARGET_HIGH, hi);
        range_settings++;
    endtask

    // One frame: a measure pass over a chosen band of grey levels, then a
    // scale pass mostly inside that band. A few frames are broken on purpose:
    // no measure pass at all, no first word, a restart part way through, or
    // stray measure words among the scale words.
    task automatic run_frame(output int sent);
        int            style;
        int            n_meas;
        int            n_scale;
        int            r;
        bit            no_first;
        mmn_pkg::pix_t band_lo;
        mmn_pkg::pix_t band_hi;
        mmn_pkg::pix_t p;
        sent  = 0;
        style = $urandom_range(5);
        case (style) inside
            0, 5:
            begin
                band_lo = 16'($urandom);
                band_hi = 16'($urandom);
                if (band_lo > band_hi)
                begin
                    p       = band_lo;
                    band_lo = band_hi;
                    band_hi = p;
                end
            end
            1:
            begin
                band_lo = 16'($urandom_range(65535 - 16));
                band_hi = band_lo + 16'($urandom_range(16));
            end
            2:
            begin
                band_lo = 16'($urandom);
                band_hi = band_lo;
            end
            3:
            begin
                band_lo = 16'd0;
                band_hi = 16'hFFFF;
            end
            default:
            begin
                band_lo = 16'($urandom_range(65535 - 3));
                band_hi = band_lo + 16'($urandom_range(3, 1));
            end
        endcase

        r        = $urandom_range(9);
        no_first = (r == 1);
        n_meas   = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8, 1);
        if (r == 0)
            n_meas = 0;
        for (int k = 0; k < n_meas; k++)
        begin
            // lead with the band ends so the measured range is the band
            if (k == 0)
                p = band_lo;
            else if (k == 1)
                p = band_hi;
            else
                p = 16'($urandom_range(band_hi, band_lo));
            if (k == 0)
                send_and_gap(mmn_pkg::MODE_MEASURE, !no_first, p);
            else
                send_and_gap(mmn_pkg::MODE_MEASURE, ($urandom_range(19) == 0), p);
            sent++;
        end

        n_scale = $urandom_range(12, 1);
        for (int k = 0; k < n_scale; k++)
        begin
            r = $urandom_range(9);
            if (r < 7)
                p = 16'($urandom_range(band_hi, band_lo));
            else if (r < 9)
                p = 16'($urandom);
            else
                p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(29) == 0)
            begin
                send_and_gap(mmn_pkg::MODE_MEASURE, 1'($urandom), 16'($urandom));
                sent++;
            end
            send_and_gap(mmn_pkg::MODE_SCALE, 1'($urandom), p);
            sent++;
        end
    endtask

    initial
    begin : stimulus
        int            sent;
        int            phase_words;
        mmn_pkg::pix_t lo;
        mmn_pkg::pix_t hi;
        mmn_pkg::pix_t tmp;

        // drive every input from time zero, with reset held low at first
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        start     = 1'b0;
        mode      = 1'b0;
        first     = 1'b0;
        pixel     = '0;
        pin_valid = 1'b0;
        pin_value = '0;
        gapless   = 1'b0;
        errors         = 0;
        results_seen   = 0;
        measure_words  = 0;
        scale_words    = 0;
        cfg_writes     = 0;
        range_settings = 0;
        stall_cycles   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: reset values first, then the corner cases
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                set_output_range(DIRECTED[i].pixel, DIRECTED[i].want);
            else
            begin
                send_word(DIRECTED[i].op, DIRECTED[i].first, DIRECTED[i].pixel,
                          DIRECTED[i].pinned, DIRECTED[i].want);
                idle_for(gap_len());
            end
        end

        // random phases, each under its own output range; the first few take
        // the extremes, and every fourth phase runs without any gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       begin lo = 16'd0;     hi = 16'hFFFF; end
                1:       begin lo = 16'd0;     hi = 16'd0;    end
                2:       begin lo = 16'hFFFF;  hi = 16'hFFFF; end
                3:       begin lo = 16'hFFFF;  hi = 16'd0;    end
                4:       begin lo = 16'd0;     hi = 16'd1;    end
                default:
                begin
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                    if (lo > hi && $urandom_range(3) != 0)
                    begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
            endcase
            gapless = 1'b0;
            set_output_range(lo, hi);
            gapless = (ph % 4 == 2);

            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE)
            begin
                run_frame(sent);
                phase_words += sent;
                // now and then hold the sender until the pipe is empty
                if ($urandom_range(14) == 0)
                    drain_results();
            end
        end

        gapless = 1'b0;
        drain_results();

        $display("covered %0d measure and %0d scale words, %0d scaled words checked",
                 measure_words, scale_words, results_seen);
        $display("over %0d output-range settings (%0d register writes)",
                 range_settings, cfg_writes);
        if (errors == 0)
            $display("** min_max_normalizer_core: PASSED **");
        else
            $display("** min_max_normalizer_core: FAILED **");
        $finish;
    end

endmodule
